[rtl/core/rupk_pkg.sv]
// Shared types and constants for the RAW10 unpack and scale block.
package rupk_pkg;

    localparam int DIM_BITS    = 14;
    localparam int CNT_BITS    = 2 * DIM_BITS;
    localparam int BYTE_BITS   = 8;
    localparam int PIX_BITS    = 10;
    localparam int LSB_BITS    = PIX_BITS - BYTE_BITS;
    localparam int GRP_PIX     = 4;
    localparam int PIX_IDX_BITS = $clog2(GRP_PIX);
    localparam int PHASE_BITS  = 3;
    localparam int SCL_BITS    = 8;
    localparam int PROD_BITS   = 18;
    localparam int DIV_SHIFT   = 10;

    localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(GRP_PIX);

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(7728);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(5368);
    localparam logic [CNT_BITS-1:0] FRAME_SIZE_RST   = CNT_BITS'(7728 * 5368);

    // Output mode codes
    localparam logic MODE_SCALED = 1'b0;
    localparam logic MODE_RAW    = 1'b1;

    // One five-byte group, reassembled into four raw pixels
    typedef struct packed {
        logic                              mode;
        logic [GRP_PIX-1:0][PIX_BITS-1:0]  pix;
    } t_group;

endpackage

[rtl/core/rupk_front.sv]
// Byte intake: collect four MSB bytes, join them with the LSB byte into a group.
module rupk_front
    import rupk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [BYTE_BITS-1:0] i_byte,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic                 i_full,
    output logic                 o_push,
    output t_group               o_grp
);

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [BYTE_BITS-1:0]  r_msb [GRP_PIX];
    logic                  accept;
    logic                  last_byte;

    assign last_byte = (r_phase == LAST_PHASE);
    // MSB bytes never need queue space; only the closing byte does
    assign o_ready   = !last_byte || !i_full;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept && last_byte;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            n_phase = last_byte ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last_byte) begin
            r_msb[r_phase[PIX_IDX_BITS-1:0]] <= i_byte;
        end
    end

    // Pixel 0 takes the top LSB pair, pixel 3 the bottom one
    always_comb begin
        o_grp.mode = i_mode;
        for (int k = 0; k < GRP_PIX; k++) begin
            o_grp.pix[k] = {r_msb[k], i_byte[(GRP_PIX-1-k)*LSB_BITS +: LSB_BITS]};
        end
    end

endmodule

[rtl/core/rupk_fifo.sv]
// Short group queue between intake and pixel output.
module rupk_fifo
    import rupk_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_group o_data
);

    t_group                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] n_count;
    logic                     do_push;
    logic                     do_pop;

    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/rupk_back.sv]
// Pixel output: walk each group, count frame pixels, scale or pass raw, register it.
module rupk_back
    import rupk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_group              i_grp,
    input  logic                i_grp_valid,
    output logic                o_pop,
    input  logic [CNT_BITS-1:0] i_frame_size,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIX_BITS-1:0] o_pixel,
    output logic                o_group_last,
    output logic                o_frame_end
);

    logic [PIX_IDX_BITS-1:0] r_pix_idx;
    logic [CNT_BITS-1:0]     r_frame_cnt;
    logic [CNT_BITS-1:0]     n_frame_cnt;
    logic [CNT_BITS:0]       cnt_inc;
    logic                    issue;
    logic                    fend;
    logic                    en_a;
    logic                    en_b;
    logic [PIX_BITS-1:0]     pix_raw;

    // stage A: raw pixel and v*255+511
    logic                    r_a_valid;
    logic                    r_a_mode;
    logic                    r_a_glast;
    logic                    r_a_fend;
    logic [PIX_BITS-1:0]     r_a_raw;
    logic [PROD_BITS-1:0]    r_a_x;
    logic [PROD_BITS-1:0]    n_a_x;

    // stage B: divide by 1023
    logic [PROD_BITS-1:0]    div_t;
    logic [SCL_BITS-1:0]     q_est;
    logic [PROD_BITS-1:0]    div_r;
    logic [SCL_BITS-1:0]     q_fix;

    logic                    r_b_valid;
    logic [PIX_BITS-1:0]     r_b_pixel;
    logic                    r_b_glast;
    logic                    r_b_fend;

    assign en_b  = !r_b_valid || i_ready;
    assign en_a  = !r_a_valid || en_b;
    assign issue = i_grp_valid && en_a;
    assign o_pop = issue && (r_pix_idx == PIX_IDX_BITS'(GRP_PIX - 1));

    assign pix_raw = i_grp.pix[r_pix_idx];
    assign cnt_inc = {1'b0, r_frame_cnt} + 1'b1;
    assign fend    = (cnt_inc >= {1'b0, i_frame_size});

    always_comb begin
        n_frame_cnt = r_frame_cnt;
        if (issue) begin
            n_frame_cnt = fend ? '0 : cnt_inc[CNT_BITS-1:0];
        end
    end

    // v*255 as (v<<8) - v, then add half of 1023 for rounding
    assign n_a_x = ({pix_raw, 8'd0} - PROD_BITS'(pix_raw)) + PROD_BITS'(511);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_idx   <= '0;
            r_frame_cnt <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
        end else begin
            r_frame_cnt <= n_frame_cnt;
            if (issue) begin
                r_pix_idx <= r_pix_idx + 1'b1;
            end
            if (en_a) begin
                r_a_valid <= issue;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_mode  <= i_grp.mode;
            r_a_glast <= (r_pix_idx == PIX_IDX_BITS'(GRP_PIX - 1));
            r_a_fend  <= fend;
            r_a_raw   <= pix_raw;
            r_a_x     <= n_a_x;
        end
    end

    // x/1023 ~ (x + x/1024)/1024 lands on the quotient or one below; fix by remainder
    assign div_t = r_a_x + (r_a_x >> DIV_SHIFT);
    assign q_est = div_t[PROD_BITS-1:DIV_SHIFT];
    assign div_r = r_a_x - {q_est, {DIV_SHIFT{1'b0}}} + PROD_BITS'(q_est);
    assign q_fix = (div_r >= PROD_BITS'(1023)) ? q_est + 1'b1 : q_est;

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            r_b_pixel <= (r_a_mode == MODE_RAW) ? r_a_raw : PIX_BITS'(q_fix);
            r_b_glast <= r_a_glast;
            r_b_fend  <= r_a_fend;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_pixel      = r_b_pixel;
    assign o_group_last = r_b_glast;
    assign o_frame_end  = r_b_fend;

`ifndef ASSERT_OFF
    a_pop_needs_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_grp_valid)
        else $error("group popped from empty queue");

    a_idx_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pix_idx == '0))
        else $error("pixel index did not wrap after group");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && fend) |=> (r_frame_cnt == '0))
        else $error("frame counter did not restart");

    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_b && r_a_valid && (r_a_mode == MODE_SCALED)) |=>
        (o_pixel[PIX_BITS-1:SCL_BITS] == '0))
        else $error("scaled pixel exceeds 8 bits");
`endif

endmodule

[rtl/core/raw10_unpack_scale_unit.sv]
// RAW10 unpack and scale: top level with configuration registers.
//
// s_axis carries the packed byte stream, one byte per transfer. Each five
// bytes (four MSB bytes, then one byte of LSB pairs, pixel 0 in bits 7:6)
// yield four pixels on m_axis: tdata[9:0] holds the pixel, tuser marks the
// fourth pixel of the group, tlast marks the final pixel of a frame of
// frame_width x frame_height pixels.
// After its fifth byte, a group's first pixel passes the queue, stage A and the
// output register; the other three follow one per cycle unless output stalls.
// The pixel stage issues one pixel a cycle, so the sustained rate, set by the
// intake, is one byte per cycle in and four pixels per five bytes out.
// A two-group queue sits between byte intake and pixel output, and an output
// register lets the input keep moving while a pixel waits.
// When m_axis_tready is low, the output holds and the queue fills; s_axis_tready
// drops only on a closing byte that finds the queue full.
// Configuration: write index 0 output_mode (0 scaled to 8 bits, 1 raw 10 bits),
// 1 frame_width, 2 frame_height; other indexes are ignored. Write only while
// idle. Reset clears the byte phase, the queue, the frame count and restores
// the register defaults (scaled, 7728 x 5368).
module raw10_unpack_scale_unit
    import rupk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0]     i_cfg_data,
    input  logic [BYTE_BITS-1:0]    s_axis_tdata,   // [7:0] packed_byte
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    output logic [15:0]             m_axis_tdata,   // [9:0] pixel_value, [15:10] zero
    output logic                    m_axis_tuser,   // [0] group_last
    output logic                    m_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready
);

    logic                r_mode;
    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;
    logic [CNT_BITS-1:0] r_frame_size;
    logic                cfg_wr;

    logic   push;
    logic   full;
    logic   pop;
    logic   grp_valid;
    t_group grp_in;
    t_group grp_out;

    logic [PIX_BITS-1:0] pixel;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SCALED;
            r_width      <= FRAME_WIDTH_RST;
            r_height     <= FRAME_HEIGHT_RST;
            r_frame_size <= FRAME_SIZE_RST;
        end else begin
            r_frame_size <= CNT_BITS'(r_width) * CNT_BITS'(r_height);
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MODE:  r_mode   <= i_cfg_data[0];
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    rupk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (s_axis_tdata),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (r_mode),
        .i_full  (full),
        .o_push  (push),
        .o_grp   (grp_in)
    );

    rupk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (grp_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (grp_valid),
        .o_data  (grp_out)
    );

    rupk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grp        (grp_out),
        .i_grp_valid  (grp_valid),
        .o_pop        (pop),
        .i_frame_size (r_frame_size),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pixel      (pixel),
        .o_group_last (m_axis_tuser),
        .o_frame_end  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, pixel};

endmodule

[tb/sv/raw10_unpack_scale_unit_tb.sv]
// Self-checking testbench for the RAW10 unpack and scale unit: random byte stream, predicted pixels.
module raw10_unpack_scale_unit_tb;
    import rupk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_CYCLES = 12;
    localparam int MAX_REPORTS = 50;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_BITS-1:0] value;
        logic                group_last;
        logic                frame_end;
    } t_pixel;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [DIM_BITS-1:0]     i_cfg_data = '0;
    logic [BYTE_BITS-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [15:0]             m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;

    raw10_unpack_scale_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expected pixels
    logic [BYTE_BITS-1:0] pending_bytes[$];
    t_pixel               expected_pixels[$];
    int unsigned          bytes_queued = 0;
    int unsigned          bytes_taken = 0;
    int unsigned          pixels_seen = 0;
    int unsigned          mismatch_count = 0;
    bit                   calm_phase = 1'b0;

    // Predictor state
    logic                  cur_mode = MODE_SCALED;
    logic [DIM_BITS-1:0]   frm_w = FRAME_WIDTH_RST;
    logic [DIM_BITS-1:0]   frm_h = FRAME_HEIGHT_RST;
    logic [PHASE_BITS-1:0] grp_phase = '0;
    logic [BYTE_BITS-1:0]  held_hi [GRP_PIX];
    int unsigned           frm_count = 0;

    logic s_fire = 1'b0;
    logic m_fire = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    function automatic int unsigned draw_wait();
        if (calm_phase) begin
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [PIX_BITS-1:0] scale_to_8(logic [PIX_BITS-1:0] v);
        int unsigned t;
        t = (int'(v) * 255 + 511) / 1023;
        return PIX_BITS'(t);
    endfunction

    task automatic unpack_byte(input logic [BYTE_BITS-1:0] b);
        t_pixel              p;
        logic [PIX_BITS-1:0] v;
        int unsigned         sz;
        if (grp_phase != LAST_PHASE) begin
            held_hi[grp_phase[PIX_IDX_BITS-1:0]] = b;
            grp_phase = grp_phase + 1'b1;
        end else begin
            grp_phase = '0;
            sz = int'(frm_w) * int'(frm_h);
            for (int k = 0; k < GRP_PIX; k++) begin
                // pixel 0 takes the top LSB pair
                v = {held_hi[k], 2'((b >> (6 - 2 * k)) & 8'h03)};
                p.value = (cur_mode == MODE_RAW) ? v : scale_to_8(v);
                p.group_last = (k == GRP_PIX - 1);
                if (frm_count + 1 >= sz) begin
                    p.frame_end = 1'b1;
                    frm_count = 0;
                end else begin
                    p.frame_end = 1'b0;
                    frm_count = frm_count + 1;
                end
                expected_pixels = {expected_pixels, p};
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("pixel %0d: %s got %0h expected %0h", pixels_seen, what, got, want);
        end
        mismatch_count++;
    endtask

    // Monitor: apply config writes, predict on byte transfers, check pixel transfers
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        s_fire <= s_axis_tvalid && s_axis_tready;
        m_fire <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MODE:  cur_mode = i_cfg_data[0];
                    CFG_FRAME_WIDTH:  frm_w = i_cfg_data;
                    CFG_FRAME_HEIGHT: frm_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                unpack_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel", m_axis_tdata, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata !== 16'(want.value))
                        report_mismatch("pixel_value", m_axis_tdata, want.value);
                    if (m_axis_tuser !== want.group_last)
                        report_mismatch("group_last", m_axis_tuser, want.group_last);
                    if (m_axis_tlast !== want.frame_end)
                        report_mismatch("frame_end", m_axis_tlast, want.frame_end);
                end
                pixels_seen++;
            end
        end
    end

    // Byte driver: hold until transfer, then wait out the drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
                s_axis_tdata <= pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                gap_left <= draw_wait();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Pixel sink: draw a stall after each transfer
    always @(negedge i_clk) begin : sink
        int unsigned n;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_fire) begin
            n = draw_wait();
            m_axis_tready <= (n == 0);
            stall_left <= (n == 0) ? 0 : n - 1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_byte(input logic [BYTE_BITS-1:0] b);
        pending_bytes = {pending_bytes, b};
        bytes_queued++;
    endtask

    // Wait until all bytes are taken, all pixels are out, and the pipe has drained
    task automatic settle();
        while (bytes_taken != bytes_queued) @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setup(input logic mode, input logic [DIM_BITS-1:0] w,
                               input logic [DIM_BITS-1:0] h);
        logic [DIM_BITS-1:0] junk;
        junk = DIM_BITS'($urandom);
        // upper data bits of the mode write carry noise
        cfg_write(CFG_OUTPUT_MODE, {junk[DIM_BITS-1:1], mode});
        cfg_write(CFG_FRAME_WIDTH, w);
        if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, DIM_BITS'($urandom));
        cfg_write(CFG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [DIM_BITS-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DIM_BITS'($urandom);
            3, 4:    return DIM_BITS'($urandom_range(1, 4));
            default: return DIM_BITS'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic stream_bytes(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       queue_byte(8'h00);
                1:       queue_byte(8'hFF);
                default: queue_byte(BYTE_BITS'($urandom));
            endcase
        end
        settle();
    endtask

    initial begin : stimulus
        int unsigned n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: all-zero group, all-ones group, mixed MSBs and LSB pairs
        for (int i = 0; i < 5; i++) queue_byte(8'h00);
        for (int i = 0; i < 5; i++) queue_byte(8'hFF);
        queue_byte(8'h80); queue_byte(8'h7F); queue_byte(8'h01); queue_byte(8'hFE);
        queue_byte(8'hE4);
        queue_byte(8'h55); queue_byte(8'hAA); queue_byte(8'hC3); queue_byte(8'h3C);
        queue_byte(8'h1B);
        settle();

        // Largest frame in raw mode, then frames ending on, inside, and at every pixel
        apply_setup(MODE_RAW, '1, '1);
        stream_bytes(20);
        apply_setup(MODE_SCALED, 14'd4, 14'd1);
        stream_bytes(20);
        apply_setup(MODE_RAW, 14'd3, 14'd1);
        stream_bytes(23);
        apply_setup(MODE_SCALED, 14'd0, 14'd7);
        stream_bytes(15);
        apply_setup(MODE_RAW, 14'd5, 14'd0);
        stream_bytes(10);
        apply_setup(MODE_SCALED, 14'd1, 14'd1);
        stream_bytes(12);

        while (bytes_queued < 470) begin
            calm_phase = ($urandom_range(0, 3) == 0);
            apply_setup(1'($urandom), pick_dim(), pick_dim());
            n = 5 * $urandom_range(1, 8);
            // sometimes leave a group open across the next setup
            if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 4);
            stream_bytes(n);
        end
        calm_phase = 1'b0;
        settle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
